// File: hdl/facm_pkg.sv
// Shared constants and types for the fully associative cache with memory.
package facm_pkg;
    localparam int NUM_LINES      = 8;
    localparam int WORDS_PER_LINE = 4;
    localparam int MEM_LINES      = 1024;
    localparam int LINE_W  = $clog2(NUM_LINES);
    localparam int OFF_W   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int TAG_W   = $clog2(MEM_LINES);
    localparam int CW_DEPTH = NUM_LINES * WORDS_PER_LINE;
    localparam int CW_AW   = $clog2(CW_DEPTH);
    localparam int MEM_DEPTH = MEM_LINES * WORDS_PER_LINE;
    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [0:0] CMD_READ  = 1'b0;
    localparam logic [0:0] CMD_WRITE = 1'b1;
    localparam logic [0:0] REG_WRITE_THROUGH = 1'b0;
    localparam logic [0:0] REG_NO_ALLOCATE   = 1'b1;
endpackage

// File: hdl/fully_assoc_cache_with_memory_unit.sv
// Top level: fully associative word cache in front of its own backing memory.
// A write hit or a non-allocating write miss answers from the lookup; a read hit also waits for
// the registered cache read. An allocating miss refills the line first, after writing back the
// victim when it is dirty; every copied word goes through a read state and a write state.
// Throughput: one item at a time; the next item is accepted the cycle after the result
// has been taken. Reset: the backing memory is cleared one word per cycle.
module fully_assoc_cache_with_memory_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // word_address[11:0], write_data[43:12], zero fill
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_data
    output logic        m_axis_tuser,   // hit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import facm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_WB_RD, S_WB_WR, S_FILL_RD, S_FILL_WR, S_FIN
    } t_state;

    t_state r_state;
    logic r_wt, r_na;
    logic [NUM_LINES-1:0] r_valid, r_dirty;
    logic [TAG_W-1:0] r_tag [NUM_LINES];
    logic [15:0] r_lfsr;
    logic r_cmd;
    logic [TAG_W-1:0] r_mline;
    logic [OFF_W-1:0] r_off;
    logic [31:0] r_wdata;
    logic [LINE_W-1:0] r_line;
    logic r_rd_pend;
    logic [OFF_W:0] r_cnt;
    logic [MEM_AW:0] r_clr;
    logic r_ovalid;
    logic [31:0] r_odata;
    logic r_ohit;

    // Cache word RAM and backing RAM ports.
    logic cw_we; logic [CW_AW-1:0] cw_wa, cw_ra; logic [31:0] cw_wd, cw_rd;
    logic bm_we; logic [MEM_AW-1:0] bm_wa, bm_ra; logic [31:0] bm_wd, bm_rd;

    facm_ram #(.WIDTH(32), .DEPTH(CW_DEPTH)) u_cw (
        .i_clk(i_clk), .i_we(cw_we), .i_waddr(cw_wa), .i_wdata(cw_wd),
        .i_raddr(cw_ra), .o_rdata(cw_rd));
    facm_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_bm (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_wa), .i_wdata(bm_wd),
        .i_raddr(bm_ra), .o_rdata(bm_rd));

    // Decode the incoming item.
    logic [11:0] in_addr;
    logic [TAG_W-1:0] in_mline;
    logic [OFF_W-1:0] in_off;
    assign in_addr  = s_axis_tdata[11:0];
    assign in_mline = TAG_W'(in_addr / WORDS_PER_LINE);
    assign in_off   = OFF_W'(in_addr % WORDS_PER_LINE);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid && !r_rd_pend;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ohit;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NO_ALLOCATE) ? {31'd0, r_na} : {31'd0, r_wt};

    // Tag search and victim choice for the held item.
    logic look_hit;
    logic [LINE_W-1:0] look_line, free_line;
    logic any_free;
    logic [15:0] lfsr_next;
    always_comb begin
        look_hit = 1'b0; look_line = '0; any_free = 1'b0; free_line = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == r_mline) begin
                look_hit = 1'b1; look_line = LINE_W'(i);
            end
            if (!r_valid[i]) begin
                any_free = 1'b1; free_line = LINE_W'(i);
            end
        end
        lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
    end

    logic [OFF_W-1:0] cnt_off;
    assign cnt_off = r_cnt[OFF_W-1:0];

    // Memory port drive.
    always_comb begin
        cw_we = 1'b0; cw_wa = CW_AW'(r_line * WORDS_PER_LINE + r_off); cw_wd = r_wdata;
        cw_ra = CW_AW'(r_line * WORDS_PER_LINE + r_off);
        bm_we = 1'b0; bm_wa = MEM_AW'(r_mline * WORDS_PER_LINE + r_off); bm_wd = r_wdata;
        bm_ra = MEM_AW'(r_mline * WORDS_PER_LINE + cnt_off);
        unique case (r_state)
            S_CLEAR: begin
                bm_we = 1'b1; bm_wa = r_clr[MEM_AW-1:0]; bm_wd = '0;
            end
            S_LOOK: begin
                if (look_hit) begin
                    cw_ra = CW_AW'(look_line * WORDS_PER_LINE + r_off);
                    cw_wa = cw_ra;
                    cw_we = (r_cmd == CMD_WRITE);
                    bm_we = (r_cmd == CMD_WRITE) && r_wt;
                end else if (r_cmd == CMD_WRITE && (r_wt || r_na)) begin
                    bm_we = 1'b1;
                end
            end
            S_WB_RD: cw_ra = CW_AW'(r_line * WORDS_PER_LINE + cnt_off);
            S_WB_WR: begin
                bm_we = 1'b1; bm_wd = cw_rd;
                bm_wa = MEM_AW'(r_tag[r_line] * WORDS_PER_LINE + cnt_off);
            end
            S_FILL_RD: ;
            S_FILL_WR: begin
                cw_we = 1'b1; cw_wd = bm_rd;
                cw_wa = CW_AW'(r_line * WORDS_PER_LINE + cnt_off);
            end
            S_FIN: begin
                cw_ra = CW_AW'(r_line * WORDS_PER_LINE + r_off);
                if (r_cmd == CMD_WRITE && !r_wt) begin
                    cw_we = 1'b1; cw_wa = cw_ra;
                end
            end
            default: ;
        endcase
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_wt <= 1'b0; r_na <= 1'b0;
            r_valid <= '0; r_dirty <= '0; r_lfsr <= LFSR_SEED; r_ovalid <= 1'b0;
            r_rd_pend <= 1'b0; r_cnt <= '0;
            for (int i = 0; i < NUM_LINES; i++) r_tag[i] <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_WRITE_THROUGH) r_wt <= pwdata[0];
                else r_na <= pwdata[0];
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_rd_pend) begin
                r_rd_pend <= 1'b0; r_ovalid <= 1'b1; r_odata <= cw_rd;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MEM_AW+1)'(MEM_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_cmd <= s_axis_tuser; r_mline <= in_mline; r_off <= in_off;
                    r_wdata <= s_axis_tdata[43:12]; r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_ohit <= look_hit; r_cnt <= '0;
                    if (look_hit) begin
                        r_line <= look_line;
                        if (r_cmd == CMD_READ) r_rd_pend <= 1'b1;
                        else begin
                            r_ovalid <= 1'b1; r_odata <= '0;
                            if (!r_wt) r_dirty[look_line] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_cmd == CMD_WRITE && r_na) begin
                        r_ovalid <= 1'b1; r_odata <= '0; r_state <= S_IDLE;
                    end else begin
                        if (any_free) r_line <= free_line;
                        else begin
                            r_lfsr <= lfsr_next;
                            r_line <= lfsr_next[LINE_W-1:0];
                        end
                        if (!any_free && r_dirty[lfsr_next[LINE_W-1:0]])
                            r_state <= S_WB_RD;
                        else r_state <= S_FILL_RD;
                    end
                end
                S_WB_RD: r_state <= S_WB_WR;
                S_WB_WR: begin
                    if (r_cnt == (OFF_W+1)'(WORDS_PER_LINE - 1)) begin
                        r_cnt <= '0; r_state <= S_FILL_RD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1; r_state <= S_WB_RD;
                    end
                end
                S_FILL_RD: r_state <= S_FILL_WR;
                S_FILL_WR: begin
                    if (r_cnt == (OFF_W+1)'(WORDS_PER_LINE - 1)) begin
                        r_cnt <= '0; r_state <= S_FIN;
                        r_tag[r_line] <= r_mline; r_valid[r_line] <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1; r_state <= S_FILL_RD;
                    end
                end
                S_FIN: begin
                    r_dirty[r_line] <= (r_cmd == CMD_WRITE) && !r_wt;
                    if (r_cmd == CMD_READ) r_rd_pend <= 1'b1;
                    else begin
                        r_ovalid <= 1'b1; r_odata <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A result never appears while the backing memory is still being cleared.
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !r_ovalid) else $error("result during clear");
    // A pending read result is taken into the output register on the next clock.
    a_rd_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_ovalid) else $error("read result lost");
    // No item is accepted while a result is still pending.
    a_no_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !s_axis_tready) else $error("accept during pending read");
    // A refill always leaves the line valid.
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> r_valid[r_line]) else $error("refilled line invalid");
endmodule

// File: hdl/facm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module facm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: dv/fully_assoc_cache_with_memory_unit_test.sv
// Self-checking testbench for the fully associative cache with backing memory.
module fully_assoc_cache_with_memory_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import facm_pkg::*;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [11:0] word_address;
        logic [31:0] write_data;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fully_assoc_cache_with_memory_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Shadow copy of the cache, the memory and the mode bits.
    logic              mode_wt, mode_na;
    logic              sh_valid [NUM_LINES];
    logic              sh_dirty [NUM_LINES];
    logic [TAG_W-1:0]  sh_tag   [NUM_LINES];
    logic [31:0]       sh_words [CW_DEPTH];
    logic [31:0]       sh_mem   [MEM_DEPTH];
    logic [15:0]       sh_lfsr;

    t_access   pending_accesses[$];
    t_response expected_responses[$];
    int        fail_count = 0;
    bit        hold_req = 0;

    // Append an item to the sender's queue.
    function automatic void queue_access(t_access a);
        pending_accesses.insert(pending_accesses.size(), a);
    endfunction

    function automatic int lookup_line(logic [TAG_W-1:0] tag);
        for (int i = 0; i < NUM_LINES; i++)
            if (sh_valid[i] && sh_tag[i] == tag) return i;
        return -1;
    endfunction

    // Victim selection, write-back of a dirty victim, then refill.
    function automatic int refill_line(logic [TAG_W-1:0] mline);
        int v;
        v = -1;
        for (int i = 0; i < NUM_LINES; i++)
            if (v < 0 && !sh_valid[i]) v = i;
        if (v < 0) begin
            sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ LFSR_TAPS) : (sh_lfsr >> 1);
            v = sh_lfsr % NUM_LINES;
        end
        if (sh_valid[v] && sh_dirty[v])
            for (int w = 0; w < WORDS_PER_LINE; w++)
                sh_mem[sh_tag[v]*WORDS_PER_LINE + w] = sh_words[v*WORDS_PER_LINE + w];
        for (int w = 0; w < WORDS_PER_LINE; w++)
            sh_words[v*WORDS_PER_LINE + w] = sh_mem[mline*WORDS_PER_LINE + w];
        sh_tag[v] = mline;
        sh_valid[v] = 1'b1;
        sh_dirty[v] = 1'b0;
        return v;
    endfunction

    function automatic t_response predict_access(t_access a);
        t_response r;
        logic [TAG_W-1:0] mline;
        int off, l;
        mline = a.word_address / WORDS_PER_LINE;
        off = a.word_address % WORDS_PER_LINE;
        l = lookup_line(mline);
        r.hit = (l >= 0);
        r.read_data = '0;
        if (a.cmd == CMD_READ) begin
            if (l < 0) l = refill_line(mline);
            r.read_data = sh_words[l*WORDS_PER_LINE + off];
        end else if (mode_wt) begin
            if (l >= 0) sh_words[l*WORDS_PER_LINE + off] = a.write_data;
            sh_mem[mline*WORDS_PER_LINE + off] = a.write_data;
            if (l < 0 && !mode_na) void'(refill_line(mline));
        end else begin
            if (l < 0 && !mode_na) l = refill_line(mline);
            if (l >= 0) begin
                sh_words[l*WORDS_PER_LINE + off] = a.write_data;
                sh_dirty[l] = 1'b1;
            end else begin
                sh_mem[mline*WORDS_PER_LINE + off] = a.write_data;
            end
        end
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    // The prediction is made here at acceptance, so items keep their order.
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        t_access a;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                a = pending_accesses.pop_front();
                expected_responses.insert(expected_responses.size(), predict_access(a));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Hold the current item until it is taken.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                a = pending_accesses[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, a.write_data, a.word_address};
                s_axis_tuser <= a.cmd;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off counted here on request.
    int rx_phase = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        rx_phase <= (rx_phase + 1) % 11;
        if (hold_req) begin
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_phase < 3) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected result data=%h hit=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                e = expected_responses.pop_front();
                if (e.read_data !== m_axis_tdata) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             e.read_data, m_axis_tdata);
                    fail_count++;
                end
                if (e.hit !== m_axis_tuser) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic apb_write(input logic [0:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_WRITE_THROUGH) mode_wt = val[0];
        else mode_na = val[0];
    endtask

    // Random access mostly within a small set of lines, so hits and evictions mix.
    function automatic t_access random_access(int hot_lines);
        t_access a;
        a.cmd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) a.word_address = 12'($urandom_range(0, 4095));
        else a.word_address = 12'($urandom_range(0, hot_lines*WORDS_PER_LINE - 1)
                                  + $urandom_range(0, 3) * 1024);
        a.write_data = $urandom();
        return a;
    endfunction

    task automatic run_phase(int count, int hot_lines);
        for (int i = 0; i < count; i++) queue_access(random_access(hot_lines));
        wait (pending_accesses.size() == 0 && expected_responses.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        t_access a;
        mode_wt = 1'b0;
        mode_na = 1'b0;
        sh_lfsr = LFSR_SEED;
        for (int i = 0; i < NUM_LINES; i++) begin
            sh_valid[i] = 0; sh_dirty[i] = 0; sh_tag[i] = '0;
        end
        for (int i = 0; i < CW_DEPTH; i++) sh_words[i] = '0;
        for (int i = 0; i < MEM_DEPTH; i++) sh_mem[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, then write-back hits and dirty eviction.
        apb_write(REG_WRITE_THROUGH, 32'd0);
        apb_write(REG_NO_ALLOCATE, 32'd0);
        a = '{CMD_READ, 12'd0, 32'd0};             queue_access(a);
        a = '{CMD_WRITE, 12'd4095, 32'hFFFF_FFFF}; queue_access(a);
        a = '{CMD_READ, 12'd4095, 32'hFFFF_FFFF};  queue_access(a);
        a = '{CMD_WRITE, 12'd1, 32'h5A5A_A5A5};    queue_access(a);
        a = '{CMD_READ, 12'd1, 32'd0};             queue_access(a);
        for (int i = 0; i < 10; i++) begin
            a = '{CMD_WRITE, 12'(i*4 + 8), 32'(i) ^ 32'hDEAD_0000};
            queue_access(a);
        end
        a = '{CMD_READ, 12'd8, 32'd0};             queue_access(a);
        a = '{CMD_READ, 12'd3, 32'd0};             queue_access(a);
        wait (pending_accesses.size() == 0 && expected_responses.size() == 0);
        repeat (40) @(posedge i_clk);

        // Write-through and no-allocate cases, then back with all four settings.
        apb_write(REG_WRITE_THROUGH, 32'd1);
        a = '{CMD_WRITE, 12'd8, 32'h1111_1111};    queue_access(a);
        a = '{CMD_WRITE, 12'd2000, 32'h2222_2222}; queue_access(a);
        run_phase(150, 12);
        apb_write(REG_NO_ALLOCATE, 32'd1);
        a = '{CMD_WRITE, 12'd3000, 32'h3333_3333}; queue_access(a);
        a = '{CMD_READ, 12'd3000, 32'd0};          queue_access(a);
        run_phase(150, 12);
        apb_write(REG_WRITE_THROUGH, 32'd0);
        run_phase(200, 10);

        // Long receiver hold-off while items keep coming.
        apb_write(REG_NO_ALLOCATE, 32'd0);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 40; i++) queue_access(random_access(10));
        @(posedge i_clk);
        wait (hold_left == 0);
        run_phase(250, 16);
        apb_write(REG_WRITE_THROUGH, 32'd1);
        run_phase(180, 9);
        apb_write(REG_WRITE_THROUGH, 32'd0);
        apb_write(REG_NO_ALLOCATE, 32'd1);
        run_phase(180, 14);

        wait (expected_responses.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("** fully_assoc_cache_with_memory_unit: PASSED **");
        else
            $display("** fully_assoc_cache_with_memory_unit: FAILED **");
        $finish;
    end

    // Run limit: reset clearing pass plus slowest items with stalls, several times over.
    initial begin
        #2_000_000;
        $display("** fully_assoc_cache_with_memory_unit: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
hdl/facm_pkg.sv
hdl/facm_ram.sv
hdl/fully_assoc_cache_with_memory_unit.sv
dv/fully_assoc_cache_with_memory_unit_test.sv
